// ----- rtl/core/mx_pkg.sv -----
package mx_pkg;

  localparam int WIDTH_DEF = 32;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [ADDR_W-3:0] REG_MODULUS = '0;
  localparam int unsigned MOD_RESET = 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_GO,
    ST_RED_WAIT,
    ST_STEP_GO,
    ST_STEP_WAIT,
    ST_FINISH
  } mx_state_t;

  typedef struct packed {
    logic load;
    logic reduce_start;
    logic reduce_update;
    logic step_start;
    logic step_update;
    logic finish;
  } mx_cmd_t;

  typedef struct packed {
    logic mod_small;
    logic mul_done;
    logic last_bit;
    logic out_free;
  } mx_status_t;

endpackage

// ----- rtl/core/modular_exponentiation.sv -----
// Channel   Direction  Contents
// s_axis    in         base, exponent
// m_axis    out        power
// apb       in/out     modulus register at byte address 0
//
// One word passes from acceptance to result through the bit-serial modular
// multipliers: one reduction pass, then one pass per exponent bit in which the
// multiply and the square run side by side.
// A modulus below two gives a result of zero without any multiplier pass.
// The result register frees the core, so the next word is taken while a result waits.
// Reset is synchronous and sets the modulus to two.
module modular_exponentiation import mx_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // base, exponent
  input  logic [((2*WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // power
  output logic [((WIDTH+7)/8)*8-1:0]        m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ADDR_W-1:0]                 paddr,
  input  logic [DATA_W-1:0]                 pwdata,
  output logic [DATA_W-1:0]                 prdata,
  output logic                              pready
);

  localparam int OUT_W = ((WIDTH + 7) / 8) * 8;

  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] power;
  logic             sel_modulus;
  mx_cmd_t          cmd;
  mx_status_t       status;

  assign sel_modulus = (paddr[ADDR_W-1:2] == REG_MODULUS);
  assign pready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(MOD_RESET);
    end else if (psel && penable && pwrite && sel_modulus) begin
      modulus <= pwdata[WIDTH-1:0];
    end
  end

  assign prdata = sel_modulus ? DATA_W'(modulus) : '0;

  mx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mx_datapath #(.WIDTH(WIDTH)) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .modulus     (modulus),
    .base        (s_axis_tdata[WIDTH-1:0]),
    .exponent    (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .power       (power),
    .power_valid (m_axis_tvalid),
    .power_ready (m_axis_tready)
  );

  assign m_axis_tdata = OUT_W'(power);

endmodule

// ----- rtl/core/mx_modmul.sv -----
module mx_modmul import mx_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] m,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [WIDTH-1:0] x_q;
  logic [WIDTH-1:0] y_q;
  logic [WIDTH-1:0] m_q;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] r_next;
  logic [WIDTH+1:0] t;
  logic [WIDTH+1:0] t1;
  logic [WIDTH+1:0] t2;
  logic [WIDTH+1:0] mm;
  logic [WIDTH+1:0] m2;

  // One multiplier bit per cycle, most significant first: r = 2r + x*bit, kept below m.
  always_comb begin
    mm = {2'b00, m_q};
    m2 = {1'b0, m_q, 1'b0};
    t  = {1'b0, r, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : '0);
    t1 = t - mm;
    t2 = t - m2;
    if (t >= m2) begin
      r_next = t2[WIDTH-1:0];
    end else if (t >= mm) begin
      r_next = t1[WIDTH-1:0];
    end else begin
      r_next = t[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(WIDTH - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_q <= x;
      y_q <= y;
      m_q <= m;
      r   <= '0;
    end else if (busy) begin
      r   <= r_next;
      y_q <= {y_q[WIDTH-2:0], 1'b0};
    end
  end

  assign result = r;

endmodule

// ----- rtl/core/mx_datapath.sv -----
module mx_datapath import mx_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  mx_cmd_t          cmd,
  output mx_status_t       status,
  input  logic [WIDTH-1:0] modulus,
  input  logic [WIDTH-1:0] base,
  input  logic [WIDTH-1:0] exponent,
  output logic [WIDTH-1:0] power,
  output logic             power_valid,
  input  logic             power_ready
);

  localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] m_q;
  logic [WIDTH-1:0] b_q;
  logic [WIDTH-1:0] acc_q;
  logic [WIDTH-1:0] e_q;
  logic [CNT_W-1:0] bit_cnt;
  logic [WIDTH-1:0] res_a;
  logic [WIDTH-1:0] res_b;
  logic [WIDTH-1:0] x_b;
  logic             done_a;
  logic             done_b;
  logic             mod_small;

  assign mod_small = (modulus[WIDTH-1:1] == '0);

  // The base is reduced first as 1 times base through the squaring unit.
  assign x_b = cmd.reduce_start ? WIDTH'(1) : b_q;

  mx_modmul #(.WIDTH(WIDTH)) u_mul_acc (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.reduce_start | cmd.step_start),
    .x      (acc_q),
    .y      (b_q),
    .m      (m_q),
    .done   (done_a),
    .result (res_a)
  );

  mx_modmul #(.WIDTH(WIDTH)) u_mul_sq (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.reduce_start | cmd.step_start),
    .x      (x_b),
    .y      (b_q),
    .m      (m_q),
    .done   (done_b),
    .result (res_b)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_q     <= modulus;
      b_q     <= base;
      e_q     <= exponent;
      acc_q   <= mod_small ? '0 : WIDTH'(1);
      bit_cnt <= '0;
    end else if (cmd.reduce_update) begin
      b_q <= res_b;
    end else if (cmd.step_update) begin
      if (e_q[0]) begin
        acc_q <= res_a;
      end
      b_q     <= res_b;
      e_q     <= {1'b0, e_q[WIDTH-1:1]};
      bit_cnt <= bit_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      power_valid <= 1'b0;
    end else if (cmd.finish) begin
      power_valid <= 1'b1;
    end else if (power_ready) begin
      power_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      power <= acc_q;
    end
  end

  assign status.mod_small = mod_small;
  assign status.mul_done  = done_a & done_b;
  assign status.last_bit  = (bit_cnt == CNT_W'(WIDTH - 1));
  assign status.out_free  = ~power_valid | power_ready;

endmodule

// ----- rtl/core/mx_ctrl.sv -----
module mx_ctrl import mx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  mx_status_t status,
  output mx_cmd_t    cmd
);

  mx_state_t state;
  mx_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.mod_small ? ST_FINISH : ST_RED_GO;
        end
      end
      ST_RED_GO: begin
        cmd.reduce_start = 1'b1;
        state_next       = ST_RED_WAIT;
      end
      ST_RED_WAIT: begin
        if (status.mul_done) begin
          cmd.reduce_update = 1'b1;
          state_next        = ST_STEP_GO;
        end
      end
      ST_STEP_GO: begin
        cmd.step_start = 1'b1;
        state_next     = ST_STEP_WAIT;
      end
      ST_STEP_WAIT: begin
        if (status.mul_done) begin
          cmd.step_update = 1'b1;
          state_next      = status.last_bit ? ST_FINISH : ST_STEP_GO;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
